@@ design/cfs_pkg.sv @@
package cfs_pkg;

	// register indexes on the configuration port
	localparam logic [1:0] CFG_FIRST_PIN   = 2'd0;
	localparam logic [1:0] CFG_PIN_COUNT   = 2'd1;
	localparam logic [1:0] CFG_CHARGE_TIME = 2'd2;
	localparam logic [1:0] CFG_PULSE_TIME  = 2'd3;

	// register reset values
	localparam logic [15:0] FIRST_PIN_RST   = 16'd0;
	localparam logic [3:0]  PIN_COUNT_RST   = 4'd8;
	localparam logic [31:0] CHARGE_TIME_RST = 32'd5000000;
	localparam logic [31:0] PULSE_TIME_RST  = 32'd50000;

	// item kinds
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_TICK  = 1'b1;

	localparam logic [3:0] MAX_PINS = 4'd8;
	localparam logic [7:0] MASK_OFF = 8'h00;

	typedef struct packed {
		logic        func;
		logic [15:0] vpin;
		logic        level;
	} item_t;

	typedef struct packed {
		logic       drive_write;
		logic [7:0] drive_mask;
		logic       coil_on;
		logic       charging;
		logic       last;
	} result_t;

	// core to pin queue
	typedef struct packed {
		logic       push;
		logic       pop;
		logic [2:0] pin;
	} q_ctrl_t;

	// pin queue to core
	typedef struct packed {
		logic       empty;
		logic [2:0] head_pin;
	} q_stat_t;

	// one or two results of a processed item
	typedef struct packed {
		logic    two;
		result_t first;
		result_t second;
	} res_pair_t;

endpackage

@@ design/cfs_ram.sv @@
module cfs_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port, registered read port (old data on a same-address write)
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

@@ design/cfs_pin_queue.sv @@
module cfs_pin_queue #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cfs_pkg::q_ctrl_t ctrl,
	output cfs_pkg::q_stat_t stat
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam logic [PW-1:0] LAST_IDX = PW'(QUEUE_DEPTH - 1);

	logic [PW-1:0] head_q, tail_q, head_d, tail_d, head_inc, tail_inc;
	logic          full;
	logic [2:0]    rd_pin;
	logic          byp_q;
	logic [2:0]    byp_pin_q;

	// wrap the ring pointers at the depth
	assign head_inc = (head_q == LAST_IDX) ? '0 : head_q + PW'(1);
	assign tail_inc = (tail_q == LAST_IDX) ? '0 : tail_q + PW'(1);
	assign full     = (tail_inc == head_q);

	// drop the oldest pin when pushing onto a full ring
	always_comb begin
		head_d = head_q;
		tail_d = tail_q;
		if (ctrl.pop || (ctrl.push && full)) begin
			head_d = head_inc;
		end
		if (ctrl.push) begin
			tail_d = tail_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			byp_q  <= 1'b0;
		end else begin
			head_q <= head_d;
			tail_q <= tail_d;
			byp_q  <= ctrl.push && (tail_q == head_d);
		end
	end

	// hold the word written to the next head entry in the same cycle
	always_ff @(posedge clk) begin
		byp_pin_q <= ctrl.pin;
	end

	// read ahead at the next head so the head pin is ready each cycle
	cfs_ram #(
		.WIDTH(3),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (ctrl.push),
		.wr_addr(tail_q),
		.wr_data(ctrl.pin),
		.rd_addr(head_d),
		.rd_data(rd_pin)
	);

	assign stat.empty    = (head_q == tail_q);
	assign stat.head_pin = byp_q ? byp_pin_q : rd_pin;

endmodule

@@ design/cfs_core.sv @@
module cfs_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	input  logic              go,
	input  cfs_pkg::item_t    item_s1,
	input  cfs_pkg::q_stat_t  q_stat,
	output cfs_pkg::q_ctrl_t  q_ctrl,
	output cfs_pkg::res_pair_t res
);

	logic [15:0] first_pin_q;
	logic [3:0]  pin_count_q;
	logic [31:0] charge_time_q, pulse_time_q;

	logic [7:0]  last_levels_q, last_levels_d;
	logic [31:0] pulse_left_q, pulse_left_d, charge_left_q, charge_left_d;
	logic        pulse_active_q, pulse_active_d;

	logic [3:0]  count;
	logic [16:0] diff;
	logic        in_range;
	logic [2:0]  pin;
	logic [7:0]  bit_sel;
	logic [31:0] pulse_dec, charge_dec;
	logic        pulse_end, do_pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_pin_q   <= cfs_pkg::FIRST_PIN_RST;
			pin_count_q   <= cfs_pkg::PIN_COUNT_RST;
			charge_time_q <= cfs_pkg::CHARGE_TIME_RST;
			pulse_time_q  <= cfs_pkg::PULSE_TIME_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				cfs_pkg::CFG_FIRST_PIN:   first_pin_q   <= cfg_data[15:0];
				cfs_pkg::CFG_PIN_COUNT:   pin_count_q   <= cfg_data[3:0];
				cfs_pkg::CFG_CHARGE_TIME: charge_time_q <= cfg_data;
				cfs_pkg::CFG_PULSE_TIME:  pulse_time_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// pin range check; a count above eight acts as eight
	assign count    = pin_count_q[3] ? cfs_pkg::MAX_PINS : pin_count_q;
	assign diff     = {1'b0, item_s1.vpin} - {1'b0, first_pin_q};
	assign in_range = !diff[16] && (diff[15:0] < {12'd0, count});
	assign pin      = diff[2:0];
	assign bit_sel  = 8'b1 << pin;

	// saturating countdowns for a tick
	assign pulse_dec  = (pulse_left_q != '0) ? pulse_left_q - 32'd1 : pulse_left_q;
	assign charge_dec = (charge_left_q != '0) ? charge_left_q - 32'd1 : charge_left_q;
	assign pulse_end  = pulse_active_q && (pulse_dec == '0);
	assign do_pop     = (charge_dec == '0) && !q_stat.empty;

	// next state and results of the item in the input register
	always_comb begin
		last_levels_d  = last_levels_q;
		pulse_left_d   = pulse_left_q;
		charge_left_d  = charge_left_q;
		pulse_active_d = pulse_active_q;
		q_ctrl         = '0;
		q_ctrl.pin     = pin;
		res            = '0;
		if (item_s1.func == cfs_pkg::FUNC_WRITE) begin
			if (in_range && !(last_levels_q[pin] && item_s1.level)) begin
				if (item_s1.level) begin
					last_levels_d = last_levels_q | bit_sel;
					if (charge_left_q != '0) begin
						q_ctrl.push = 1'b1;
					end else begin
						pulse_active_d          = 1'b1;
						pulse_left_d            = pulse_time_q;
						charge_left_d           = charge_time_q;
						res.first.drive_write   = 1'b1;
						res.first.drive_mask    = bit_sel;
					end
				end else begin
					last_levels_d = last_levels_q & ~bit_sel;
				end
			end
			res.first.coil_on  = pulse_active_d;
			res.first.charging = (charge_left_d != '0);
			res.first.last     = 1'b1;
		end else begin
			pulse_left_d  = pulse_dec;
			charge_left_d = charge_dec;
			if (pulse_end) begin
				pulse_active_d = 1'b0;
			end
			// the pulse end word, when there is one, goes first
			res.first.drive_write = pulse_end;
			res.first.drive_mask  = cfs_pkg::MASK_OFF;
			res.first.coil_on     = pulse_active_d;
			res.first.charging    = (charge_dec != '0);
			res.first.last        = !(pulse_end && do_pop);
			if (do_pop) begin
				q_ctrl.pop             = 1'b1;
				pulse_active_d         = 1'b1;
				pulse_left_d           = pulse_time_q;
				charge_left_d          = charge_time_q;
				res.second.drive_write = 1'b1;
				res.second.drive_mask  = 8'b1 << q_stat.head_pin;
				res.second.coil_on     = 1'b1;
				res.second.charging    = (charge_time_q != '0);
				res.second.last        = 1'b1;
				if (pulse_end) begin
					res.two = 1'b1;
				end else begin
					res.first = res.second;
				end
			end
		end
		if (!go) begin
			q_ctrl.push = 1'b0;
			q_ctrl.pop  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_levels_q  <= '0;
			pulse_left_q   <= '0;
			charge_left_q  <= '0;
			pulse_active_q <= 1'b0;
		end else if (go) begin
			last_levels_q  <= last_levels_d;
			pulse_left_q   <= pulse_left_d;
			charge_left_q  <= charge_left_d;
			pulse_active_q <= pulse_active_d;
		end
	end

endmodule

@@ design/cfs_out_fifo.sv @@
module cfs_out_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  cfs_pkg::res_pair_t res,
	output logic               room2,
	output logic               result_valid,
	input  logic               result_ready,
	output cfs_pkg::result_t   result
);

	cfs_pkg::result_t entry_q [4];
	logic [1:0] wptr_q, rptr_q;
	logic [2:0] count_q;
	logic [2:0] n_in, n_out;

	assign n_in  = push ? (res.two ? 3'd2 : 3'd1) : 3'd0;
	assign n_out = (result_valid && result_ready) ? 3'd1 : 3'd0;

	// write one or two words per processed item
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= res.first;
			if (res.two) begin
				entry_q[wptr_q + 2'd1] <= res.second;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + n_in[1:0];
			rptr_q  <= rptr_q + n_out[1:0];
			count_q <= count_q + n_in - n_out;
		end
	end

	assign room2        = (count_q <= 3'd2);
	assign result_valid = (count_q != '0);
	assign result       = entry_q[rptr_q];

endmodule

@@ design/coil_fire_scheduler_unit.sv @@
// Coil fire scheduler.
// Item channel (item_valid/item_ready/item): a pin write (func 0) with vpin
// and level, or a one microsecond tick (func 1). Result channel
// (result_valid/result_ready/result): one word per item, or two for a tick
// that ends a pulse and fires a queued pin on the same tick; last marks the
// final word of an item. Configuration channel (cfg_valid/cfg_ready,
// cfg_index, cfg_data) is always ready; write it only while the block is idle.
// An accepted item waits in the input register until the output queue has
// room for two words; its result words are then written into that queue.
// Throughput: one item per cycle while the receiver keeps up; the output
// queue of four words drains one word per cycle, so it absorbs the first
// extra word, and after that each two-word tick holds the next item in the
// input register while the queue drains.
// Reset clears the timers, levels, queue pointers and output queue and loads
// the register defaults; no item is lost on reset release.
// When the receiver stalls, results wait in the output queue and item_ready
// drops once the input register is full and fewer than two free slots remain.
module coil_fire_scheduler_unit #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  cfs_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output cfs_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [31:0]      cfg_data
);

	logic               valid_s1;
	cfs_pkg::item_t     item_s1;
	logic               room2, go;
	cfs_pkg::q_ctrl_t   q_ctrl;
	cfs_pkg::q_stat_t   q_stat;
	cfs_pkg::res_pair_t res;

	assign cfg_ready  = 1'b1;
	assign go         = valid_s1 && room2;
	assign item_ready = !valid_s1 || go;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	cfs_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.go       (go),
		.item_s1  (item_s1),
		.q_stat   (q_stat),
		.q_ctrl   (q_ctrl),
		.res      (res)
	);

	cfs_pin_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (q_ctrl),
		.stat  (q_stat)
	);

	cfs_out_fifo u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (go),
		.res         (res),
		.room2       (room2),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

endmodule

@@ design/cfs_checker.sv @@
module cfs_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             result_valid,
	input logic             result_ready,
	input cfs_pkg::result_t result
);

	// a stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("stalled result word changed");

	// a fire word is one-hot and shows the pulse running
	a_fire: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.drive_write && result.drive_mask != 8'h00
		|-> $onehot(result.drive_mask) && result.coil_on)
		else $error("fire word not one-hot or coil off");

	// a pulse end word shows the coil off
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.drive_write && result.drive_mask == 8'h00
		|-> !result.coil_on)
		else $error("pulse end word with coil on");

	// a word without a new mask carries an empty mask
	a_nomask: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.drive_write |-> result.drive_mask == 8'h00)
		else $error("mask set without drive_write");

endmodule

bind coil_fire_scheduler_unit cfs_checker u_cfs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result      (result)
);
